[hw/rtl/dlc_pkg.sv]
// Package for the door lock controller: shared types, reply codes, register map.
// No dependencies; imported by every module of the block.
package dlc_pkg;

    localparam int CODE_LENGTH = 5;
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [7:0] RSP_MATCH    = 8'h11;
    localparam logic [7:0] RSP_MISMATCH = 8'h00;
    localparam logic [7:0] RSP_OPENING  = 8'h01;
    localparam logic [7:0] RSP_OPENED   = 8'hc1;
    localparam logic [7:0] RSP_CLOSING  = 8'hc2;
    localparam logic [7:0] RSP_DONE     = 8'hFF;
    localparam logic [7:0] CMD_OPEN     = 8'h2B;
    localparam logic [7:0] CMD_CHANGE   = 8'h2D;

    localparam logic [1:0] MOTOR_STOP = 2'd0;
    localparam logic [1:0] MOTOR_FWD  = 2'd1;
    localparam logic [1:0] MOTOR_REV  = 2'd2;

    localparam logic [2:0] REG_OPEN_TIME  = 3'd0;
    localparam logic [2:0] REG_HOLD_TIME  = 3'd1;
    localparam logic [2:0] REG_CLOSE_TIME = 3'd2;
    localparam logic [2:0] REG_ALARM_TIME = 3'd3;
    localparam logic [2:0] REG_MAX_FAIL   = 3'd4;

    localparam logic [15:0] OPEN_TIME_RST  = 16'd5000;
    localparam logic [15:0] HOLD_TIME_RST  = 16'd3000;
    localparam logic [15:0] CLOSE_TIME_RST = 16'd5000;
    localparam logic [15:0] ALARM_TIME_RST = 16'd6000;
    localparam logic [2:0]  MAX_FAIL_RST   = 3'd3;

    typedef enum logic [10:0] {
        PH_SETUP_A   = 11'b000_0000_0001,
        PH_SETUP_B   = 11'b000_0000_0010,
        PH_IDLE      = 11'b000_0000_0100,
        PH_OPEN_CODE = 11'b000_0000_1000,
        PH_CHG_CODE  = 11'b000_0001_0000,
        PH_NEW_A     = 11'b000_0010_0000,
        PH_NEW_B     = 11'b000_0100_0000,
        PH_OPENING   = 11'b000_1000_0000,
        PH_HOLD      = 11'b001_0000_0000,
        PH_CLOSING   = 11'b010_0000_0000,
        PH_ALARM     = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        logic       tick;
        logic       is_open;
        logic       is_change;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic [1:0] motor_drive;
        logic       alarm_on;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [15:0] open_time;
        logic [15:0] hold_time;
        logic [15:0] close_time;
        logic [15:0] alarm_time;
        logic [2:0]  max_failures;
    } cfg_t;

endpackage

[hw/rtl/dlc_front.sv]
// Front end: accepts requests, tags ticks and command bytes, queues them.
// Depends on dlc_pkg.
module dlc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           mode,
    input  logic [7:0]     rx_byte,
    output logic           q_valid,
    output dlc_pkg::item_t q_item,
    input  logic           q_pop
);
    import dlc_pkg::*;

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              push;
    item_t             new_item;

    assign in_stall = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        new_item.tick      = mode;
        new_item.is_open   = !mode && (rx_byte == CMD_OPEN);
        new_item.is_change = !mode && (rx_byte == CMD_CHANGE);
        new_item.data      = rx_byte;
        wp_next  = push ? wp_reg + 1'b1 : wp_reg;
        rp_next  = q_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/dlc_core.sv]
// Back end: lock state machine, code compare, phase timer, failure count.
// Depends on dlc_pkg; fed by dlc_front, drains into dlc_out.
module dlc_core (
    input  logic             clk,
    input  logic             rst_n,
    input  dlc_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  dlc_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic             room,
    output logic [1:0]       push_cnt,
    output dlc_pkg::result_t res0,
    output dlc_pkg::result_t res1
);
    import dlc_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             mis_reg, mis_next;
    logic [2:0]       fail_reg, fail_next;
    logic [15:0]      timer_reg, timer_next;
    logic [7:0]       first_entry_reg [CODE_LENGTH];
    logic [7:0]       stored_code_reg [CODE_LENGTH];

    logic        exec;
    logic        last_byte;
    logic        mis_base;
    logic        mis_fe;
    logic        mis_sc;
    logic        fe_we;
    logic        copy_code;
    logic [15:0] timer_dec;
    logic [2:0]  fail_inc;
    logic [1:0]  tx_n;
    logic [7:0]  tx0;
    logic [7:0]  tx1;
    logic [1:0]  motor;
    logic        alarm;

    assign exec      = q_valid && room;
    assign q_pop     = exec;
    assign last_byte = (idx_reg == IDX_W'(CODE_LENGTH - 1));
    assign mis_base  = (idx_reg == '0) ? 1'b0 : mis_reg;
    assign mis_fe    = mis_base || (first_entry_reg[idx_reg] != q_item.data);
    assign mis_sc    = mis_base || (stored_code_reg[idx_reg] != q_item.data);
    assign timer_dec = (timer_reg != '0) ? timer_reg - 16'd1 : timer_reg;
    assign fail_inc  = fail_reg + 3'd1;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        mis_next   = mis_reg;
        fail_next  = fail_reg;
        timer_next = timer_reg;
        fe_we      = 1'b0;
        copy_code  = 1'b0;
        tx_n       = 2'd0;
        tx0        = 8'h00;
        tx1        = 8'h00;
        if (exec)
        begin
            if (q_item.tick)
            begin
                unique case (phase_reg)
                    PH_OPENING, PH_HOLD, PH_CLOSING, PH_ALARM:
                    begin
                        timer_next = timer_dec;
                        if (timer_dec == '0)
                        begin
                            unique case (phase_reg)
                                PH_OPENING:
                                begin
                                    tx_n       = 2'd1;
                                    tx0        = RSP_OPENED;
                                    phase_next = PH_HOLD;
                                    timer_next = cfg.hold_time;
                                end
                                PH_HOLD:
                                begin
                                    tx_n       = 2'd1;
                                    tx0        = RSP_CLOSING;
                                    phase_next = PH_CLOSING;
                                    timer_next = cfg.close_time;
                                end
                                PH_CLOSING:
                                begin
                                    tx_n       = 2'd1;
                                    tx0        = RSP_DONE;
                                    phase_next = PH_IDLE;
                                end
                                default:
                                begin
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                unique case (phase_reg)
                    PH_SETUP_A, PH_NEW_A:
                    begin
                        fe_we    = 1'b1;
                        mis_next = mis_base;
                        idx_next = last_byte ? '0 : IDX_W'(idx_reg + 1'b1);
                        if (last_byte)
                        begin
                            phase_next = (phase_reg == PH_SETUP_A) ? PH_SETUP_B : PH_NEW_B;
                        end
                    end
                    PH_SETUP_B, PH_NEW_B:
                    begin
                        mis_next = mis_fe;
                        idx_next = last_byte ? '0 : IDX_W'(idx_reg + 1'b1);
                        if (last_byte)
                        begin
                            tx_n       = 2'd1;
                            tx0        = mis_fe ? RSP_MISMATCH : RSP_MATCH;
                            copy_code  = !mis_fe;
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_IDLE:
                    begin
                        if (q_item.is_open)
                        begin
                            phase_next = PH_OPEN_CODE;
                            idx_next   = '0;
                        end
                        else if (q_item.is_change)
                        begin
                            phase_next = PH_CHG_CODE;
                            idx_next   = '0;
                        end
                    end
                    PH_OPEN_CODE, PH_CHG_CODE:
                    begin
                        mis_next = mis_sc;
                        idx_next = last_byte ? '0 : IDX_W'(idx_reg + 1'b1);
                        if (last_byte)
                        begin
                            tx_n = 2'd1;
                            if (!mis_sc)
                            begin
                                tx0       = RSP_MATCH;
                                fail_next = 3'd0;
                                if (phase_reg == PH_OPEN_CODE)
                                begin
                                    tx_n       = 2'd2;
                                    tx1        = RSP_OPENING;
                                    phase_next = PH_OPENING;
                                    timer_next = cfg.open_time;
                                end
                                else
                                begin
                                    phase_next = PH_NEW_A;
                                end
                            end
                            else
                            begin
                                tx0 = RSP_MISMATCH;
                                if (fail_inc == cfg.max_failures)
                                begin
                                    fail_next  = 3'd0;
                                    phase_next = PH_ALARM;
                                    timer_next = cfg.alarm_time;
                                end
                                else
                                begin
                                    fail_next  = fail_inc;
                                    phase_next = PH_IDLE;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        motor = (phase_next == PH_OPENING) ? MOTOR_FWD :
                (phase_next == PH_CLOSING) ? MOTOR_REV : MOTOR_STOP;
        alarm = (phase_next == PH_ALARM);

        res0.tx_valid    = (tx_n != 2'd0);
        res0.tx_byte     = tx0;
        res0.motor_drive = motor;
        res0.alarm_on    = alarm;
        res0.last        = (tx_n != 2'd2);
        res1.tx_valid    = 1'b1;
        res1.tx_byte     = tx1;
        res1.motor_drive = motor;
        res1.alarm_on    = alarm;
        res1.last        = 1'b1;
        push_cnt = !exec ? 2'd0 : (tx_n == 2'd2) ? 2'd2 : 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (fe_we)
        begin
            first_entry_reg[idx_reg] <= q_item.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SETUP_A;
            idx_reg   <= '0;
            mis_reg   <= 1'b0;
            fail_reg  <= 3'd0;
            timer_reg <= '0;
            for (int i = 0; i < CODE_LENGTH; i++)
            begin
                stored_code_reg[i] <= 8'h00;
            end
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            mis_reg   <= mis_next;
            fail_reg  <= fail_next;
            timer_reg <= timer_next;
            if (copy_code)
            begin
                for (int i = 0; i < CODE_LENGTH; i++)
                begin
                    stored_code_reg[i] <= first_entry_reg[i];
                end
            end
        end
    end

endmodule

[hw/rtl/dlc_out.sv]
// Result queue: takes one or two results per request, one out per cycle unless stalled.
// Depends on dlc_pkg.
module dlc_out (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_cnt,
    input  dlc_pkg::result_t res0,
    input  dlc_pkg::result_t res1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_stall,
    output dlc_pkg::result_t out_res
);
    import dlc_pkg::*;

    result_t           mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, wp_next;
    logic [QPTR_W-1:0] rp_reg, rp_next;
    logic [QPTR_W:0]   cnt_reg, cnt_next;
    logic              pop;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem_reg[rp_reg];
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg <= (QPTR_W+1)'(QDEPTH - 2));

    always_comb
    begin
        wp_next  = wp_reg + QPTR_W'(push_cnt);
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push_cnt) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wp_reg] <= res0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[QPTR_W'(wp_reg + 1'b1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/password_door_lock_controller_unit.sv]
// Door lock controller, top level: register port, front queue, lock engine, result queue.
// Depends on dlc_pkg, dlc_front, dlc_core, dlc_out.
//
// One request per clock cycle is accepted unless in_stall is raised. A request is
// either a received byte (mode 0) or a one-millisecond tick (mode 1). Each
// request yields one result, or two for a matching open code (0x11 then 0x01);
// the result queue hands out one result per cycle while out_stall is low. The
// engine runs a request once the result queue has room for two results.
// Requests wait in a four-entry queue, results in another, so both sides may
// stall independently. Registers: open, hold, close and alarm times at byte
// addresses 0x0 to 0xC, failure limit at 0x10; write them only while the block
// is idle.
module password_door_lock_controller_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [dlc_pkg::ADDR_W-1:0] paddr,
    input  logic [dlc_pkg::DATA_W-1:0] pwdata,
    output logic [dlc_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       mode,
    input  logic [7:0]                 rx_byte,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       tx_valid,
    output logic [7:0]                 tx_byte,
    output logic [1:0]                 motor_drive,
    output logic                       alarm_on,
    output logic                       last
);
    import dlc_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;
    logic       q_valid;
    item_t      q_item;
    logic       q_pop;
    logic       room;
    logic [1:0] push_cnt;
    result_t    res0;
    result_t    res1;
    result_t    out_res;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb
    begin
        unique case (reg_idx)
            REG_OPEN_TIME:  prdata = DATA_W'(cfg_reg.open_time);
            REG_HOLD_TIME:  prdata = DATA_W'(cfg_reg.hold_time);
            REG_CLOSE_TIME: prdata = DATA_W'(cfg_reg.close_time);
            REG_ALARM_TIME: prdata = DATA_W'(cfg_reg.alarm_time);
            REG_MAX_FAIL:   prdata = DATA_W'(cfg_reg.max_failures);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_time    <= OPEN_TIME_RST;
            cfg_reg.hold_time    <= HOLD_TIME_RST;
            cfg_reg.close_time   <= CLOSE_TIME_RST;
            cfg_reg.alarm_time   <= ALARM_TIME_RST;
            cfg_reg.max_failures <= MAX_FAIL_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_OPEN_TIME:  cfg_reg.open_time    <= pwdata[15:0];
                REG_HOLD_TIME:  cfg_reg.hold_time    <= pwdata[15:0];
                REG_CLOSE_TIME: cfg_reg.close_time   <= pwdata[15:0];
                REG_ALARM_TIME: cfg_reg.alarm_time   <= pwdata[15:0];
                REG_MAX_FAIL:   cfg_reg.max_failures <= pwdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    dlc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .rx_byte  (rx_byte),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    dlc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .room     (room),
        .push_cnt (push_cnt),
        .res0     (res0),
        .res1     (res1)
    );

    dlc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .res0      (res0),
        .res1      (res1),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign tx_valid    = out_res.tx_valid;
    assign tx_byte     = out_res.tx_byte;
    assign motor_drive = out_res.motor_drive;
    assign alarm_on    = out_res.alarm_on;
    assign last        = out_res.last;

endmodule

[hw/rtl/dlc_checker.sv]
// Port-level checks for the door lock controller, bound to the top level.
// Depends on dlc_pkg and password_door_lock_controller_unit.
module dlc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       tx_valid,
    input logic [7:0] tx_byte,
    input logic [1:0] motor_drive,
    input logic       alarm_on,
    input logic       last
);
    import dlc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid
            && $stable({tx_valid, tx_byte, motor_drive, alarm_on, last}))
        else $error("stalled result changed");

    // a status-only result is the sole result of its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tx_valid |-> last && (tx_byte == RSP_MISMATCH))
        else $error("bad status result");

    // a non-final result is always the match reply of an open
    a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> tx_valid && (tx_byte == RSP_MATCH)
            && (motor_drive == MOTOR_FWD))
        else $error("bad first result of a pair");

    // motor and alarm never active together, motor code in range
    a_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_drive != 2'd3) && !(alarm_on && (motor_drive != MOTOR_STOP)))
        else $error("bad motor or alarm level");

endmodule

bind password_door_lock_controller_unit dlc_checker u_dlc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .tx_valid    (tx_valid),
    .tx_byte     (tx_byte),
    .motor_drive (motor_drive),
    .alarm_on    (alarm_on),
    .last        (last)
);

[bench/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for password_door_lock_controller_unit: code entry, open, change, alarm.
// Depends on dlc_pkg and the RTL; a scoreboard class predicts every result of each request.

module testbench;
    import dlc_pkg::*;

    class lock_scoreboard;
        result_t     pending_replies[$];
        int          errors;
        logic [15:0] open_ms, hold_ms, close_ms, alarm_ms;
        logic [2:0]  fail_limit;
        phase_t      phase;
        logic [2:0]  code_pos;
        logic [7:0]  entry_a[CODE_LENGTH];
        logic [7:0]  lock_code[CODE_LENGTH];
        bit          differs;
        logic [2:0]  fail_count;
        logic [15:0] timer;
        logic [7:0]  replies[$];

        function new();
            errors     = 0;
            open_ms    = OPEN_TIME_RST;
            hold_ms    = HOLD_TIME_RST;
            close_ms   = CLOSE_TIME_RST;
            alarm_ms   = ALARM_TIME_RST;
            fail_limit = MAX_FAIL_RST;
            phase      = PH_SETUP_A;
            code_pos   = '0;
            differs    = 1'b0;
            fail_count = '0;
            timer      = '0;
            foreach (lock_code[i])
            begin
                lock_code[i] = 8'h00;
                entry_a[i]   = 8'h00;
            end
        endfunction

        function void set_register(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_OPEN_TIME:  open_ms    = value[15:0];
                REG_HOLD_TIME:  hold_ms    = value[15:0];
                REG_CLOSE_TIME: close_ms   = value[15:0];
                REG_ALARM_TIME: alarm_ms   = value[15:0];
                REG_MAX_FAIL:   fail_limit = value[2:0];
                default: ;
            endcase
        endfunction

        function bit in_timed_phase();
            return phase inside {PH_OPENING, PH_HOLD, PH_CLOSING, PH_ALARM};
        endfunction

        function logic [39:0] current_code();
            logic [39:0] c;
            for (int i = 0; i < CODE_LENGTH; i++)
                c[8*i +: 8] = lock_code[i];
            return c;
        endfunction

        // returns 1 once the last byte of a code has been taken
        function bit take_code_byte(logic [7:0] b, bit keep, bit vs_lock);
            int i;
            i = code_pos;
            if (i >= CODE_LENGTH)
                i = 0;
            if (i == 0)
                differs = 1'b0;
            if (keep)
                entry_a[i] = b;
            else if ((vs_lock ? lock_code[i] : entry_a[i]) != b)
                differs = 1'b1;
            if (i + 1 >= CODE_LENGTH)
            begin
                code_pos = '0;
                return 1'b1;
            end
            code_pos = 3'(i + 1);
            return 1'b0;
        endfunction

        // predicts the results of one accepted request; returns 0 if the request is ignored
        function bit add_request(bit tick, logic [7:0] b);
            bit         effect;
            int         n;
            result_t    r;
            logic [1:0] motor;
            effect = 1'b1;
            replies.delete();
            if (tick)
            begin
                if (!in_timed_phase())
                    effect = 1'b0;
                else
                begin
                    if (timer != 0)
                        timer--;
                    if (timer == 0)
                    begin
                        case (phase)
                            PH_OPENING:
                            begin
                                replies.push_back(RSP_OPENED);
                                phase = PH_HOLD;
                                timer = hold_ms;
                            end
                            PH_HOLD:
                            begin
                                replies.push_back(RSP_CLOSING);
                                phase = PH_CLOSING;
                                timer = close_ms;
                            end
                            PH_CLOSING:
                            begin
                                replies.push_back(RSP_DONE);
                                phase = PH_IDLE;
                            end
                            default: phase = PH_IDLE;
                        endcase
                    end
                end
            end
            else
            begin
                case (phase)
                    PH_SETUP_A, PH_NEW_A:
                        if (take_code_byte(b, 1'b1, 1'b0))
                            phase = (phase == PH_SETUP_A) ? PH_SETUP_B : PH_NEW_B;
                    PH_SETUP_B, PH_NEW_B:
                        if (take_code_byte(b, 1'b0, 1'b0))
                        begin
                            if (!differs)
                            begin
                                lock_code = entry_a;
                                replies.push_back(RSP_MATCH);
                            end
                            else
                                replies.push_back(RSP_MISMATCH);
                            phase = PH_IDLE;
                        end
                    PH_IDLE:
                        if (b == CMD_OPEN)
                        begin
                            phase    = PH_OPEN_CODE;
                            code_pos = '0;
                        end
                        else if (b == CMD_CHANGE)
                        begin
                            phase    = PH_CHG_CODE;
                            code_pos = '0;
                        end
                        else
                            effect = 1'b0;
                    PH_OPEN_CODE, PH_CHG_CODE:
                        if (take_code_byte(b, 1'b0, 1'b1))
                        begin
                            if (!differs)
                            begin
                                replies.push_back(RSP_MATCH);
                                fail_count = '0;
                                if (phase == PH_OPEN_CODE)
                                begin
                                    replies.push_back(RSP_OPENING);
                                    phase = PH_OPENING;
                                    timer = open_ms;
                                end
                                else
                                    phase = PH_NEW_A;
                            end
                            else
                            begin
                                replies.push_back(RSP_MISMATCH);
                                fail_count = fail_count + 3'd1;
                                if (fail_count == fail_limit)
                                begin
                                    fail_count = '0;
                                    phase      = PH_ALARM;
                                    timer      = alarm_ms;
                                end
                                else
                                    phase = PH_IDLE;
                            end
                        end
                    default: effect = 1'b0;
                endcase
            end
            motor = (phase == PH_OPENING) ? MOTOR_FWD :
                    (phase == PH_CLOSING) ? MOTOR_REV : MOTOR_STOP;
            n = (replies.size() > 0) ? replies.size() : 1;
            for (int k = 0; k < n; k++)
            begin
                r.tx_valid    = replies.size() > 0;
                r.tx_byte     = (replies.size() > 0) ? replies[k] : 8'h00;
                r.motor_drive = motor;
                r.alarm_on    = phase == PH_ALARM;
                r.last        = k == n - 1;
                pending_replies.push_back(r);
            end
            return effect;
        endfunction

        function void check_reply(result_t got);
            result_t want;
            if (pending_replies.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %0d/%02h/%0d/%0d/%0d",
                             got.tx_valid, got.tx_byte, got.motor_drive,
                             got.alarm_on, got.last);
                return;
            end
            want = pending_replies.pop_front();
            if (got.tx_valid !== want.tx_valid || got.tx_byte !== want.tx_byte ||
                got.motor_drive !== want.motor_drive || got.alarm_on !== want.alarm_on ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch %0t: exp %0d/%02h/%0d/%0d/%0d got %0d/%02h/%0d/%0d/%0d",
                             $realtime, want.tx_valid, want.tx_byte, want.motor_drive,
                             want.alarm_on, want.last, got.tx_valid, got.tx_byte,
                             got.motor_drive, got.alarm_on, got.last);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 2_000_000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic                mode      = 1'b0;
    logic [7:0]          rx_byte   = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                tx_valid;
    logic [7:0]          tx_byte;
    logic [1:0]          motor_drive;
    logic                alarm_on;
    logic                last;

    logic                idle_on       = 1'b1;
    logic                start_holdoff = 1'b0;
    int                  holdoff_left  = 0;
    int                  cycle_count   = 0;
    int                  counted       = 0;

    lock_scoreboard sb = new();

    password_door_lock_controller_unit u_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("password_door_lock_controller_unit test failed");
            $finish;
        end
    end

    // result side: check, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_reply(result_t'{tx_valid, tx_byte, motor_drive, alarm_on, last});
        if (start_holdoff)
            holdoff_left <= 400;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        out_stall <= start_holdoff || holdoff_left > 1 ||
                     (idle_on && $urandom_range(99) < 38);
    end

    task automatic send_item(bit tick, logic [7:0] b);
        while (idle_on && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= tick;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (sb.add_request(tick, b))
            counted++;
    endtask

    task automatic send_code(logic [39:0] c);
        for (int i = 0; i < CODE_LENGTH; i++)
            send_item(1'b0, c[8*i +: 8]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic run_out_timers();
        while (sb.in_timed_phase())
            send_item(1'b1, 8'($urandom));
        drain();
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    task automatic write_config(logic [15:0] t_open, logic [15:0] t_hold,
                                logic [15:0] t_close, logic [15:0] t_alarm,
                                logic [2:0] fails);
        write_reg(REG_OPEN_TIME, {16'h0, t_open});
        write_reg(REG_HOLD_TIME, {16'h0, t_hold});
        write_reg(REG_CLOSE_TIME, {16'h0, t_close});
        write_reg(REG_ALARM_TIME, {16'h0, t_alarm});
        write_reg(REG_MAX_FAIL, {29'h0, fails});
    endtask

    function automatic logic [39:0] random_code();
        return {8'($urandom), 32'($urandom)};
    endfunction

    function automatic logic [39:0] spoil(logic [39:0] c);
        return c ^ (40'($urandom_range(1, 255)) << (8 * $urandom_range(0, 4)));
    endfunction

    function automatic logic [15:0] short_time();
        return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
    endfunction

    // one well-formed sequence (or a bit of noise) from the current phase
    task automatic run_scenario();
        logic [39:0] c;
        int          pick;
        pick = $urandom_range(99);
        if (sb.in_timed_phase())
        begin
            while (sb.in_timed_phase())
                if ($urandom_range(99) < 88)
                    send_item(1'b1, 8'($urandom));
                else
                    send_item(1'b0, 8'($urandom));
        end
        else if (sb.phase == PH_SETUP_A || sb.phase == PH_NEW_A)
        begin
            c = random_code();
            send_code(c);
            send_code(pick < 70 ? c : pick < 85 ? spoil(c) : random_code());
        end
        else if (sb.phase == PH_IDLE)
        begin
            if (pick < 70)
            begin
                send_item(1'b0, pick < 45 ? CMD_OPEN : CMD_CHANGE);
                pick = $urandom_range(99);
                c = sb.current_code();
                if (pick < 4)
                    for (int i = $urandom_range(1, 4); i > 0; i--)
                        send_item(1'b0, 8'($urandom));
                else
                    send_code(pick < 75 ? c : pick < 90 ? spoil(c) : random_code());
            end
            else if (pick < 85)
                send_item(1'b0, 8'($urandom));
            else
                for (int i = $urandom_range(1, 3); i > 0; i--)
                    send_item(1'b1, 8'($urandom));
        end
        else
            send_item(1'b0, 8'($urandom));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // setup codes differ: stored code stays zero
        send_code(40'h80_FF_00_FF_00);
        send_code(40'h80_FF_00_FF_01);
        send_item(1'b1, 8'hA5);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h2A);
        drain();
        write_config(16'd20, 16'd7, 16'd15, 16'd25, 3'd3);
        // open with the zero code, short timing
        send_item(1'b0, CMD_OPEN);
        send_code(40'h0);
        send_item(1'b0, CMD_CHANGE);
        run_out_timers();
        send_item(1'b0, CMD_CHANGE);
        send_code(40'h0);
        send_code(40'hFF_FF_FF_FF_FF);
        send_code(40'hFF_FF_FF_FF_FF);
        // three wrong codes sound the alarm
        for (int i = 0; i < 3; i++)
        begin
            send_item(1'b0, CMD_OPEN);
            send_code(40'h0);
        end
        send_item(1'b0, CMD_OPEN);
        run_out_timers();
        send_item(1'b0, CMD_CHANGE);
        send_code(40'hFF_FF_FF_FF_FF);
        send_code(40'h01);
        send_code(40'h02);
        drain();

        write_config(16'd40, 16'h0, 16'h1, 16'd30, 3'd1);
        send_item(1'b0, CMD_OPEN);
        send_code(40'hFF_FF_FF_FF_FF);
        run_out_timers();
        send_item(1'b0, CMD_OPEN);
        send_code(40'hFF_FF_FF_FF_FE);
        run_out_timers();

        // zero limit: count wraps, alarm on the eighth failure
        write_config(16'h0, 16'h0, 16'h0, 16'h0, 3'd0);
        send_item(1'b0, CMD_OPEN);
        send_code(40'hFF_FF_FF_FF_FF);
        run_out_timers();
        for (int i = 0; i < 8; i++)
        begin
            send_item(1'b0, CMD_OPEN);
            send_code(40'h0);
        end
        run_out_timers();

        counted = 0;
        for (int p = 0; p < 6; p++)
        begin
            run_out_timers();
            write_config(short_time(), short_time(), short_time(), short_time(),
                         p == 5 ? 3'd7 : 3'($urandom_range(1, 7)));
            idle_on <= (p != 2);
            if (p == 3)
            begin
                in_valid      <= 1'b0;
                start_holdoff <= 1'b1;
                @(posedge clk);
                start_holdoff <= 1'b0;
            end
            while (counted < (p + 1) * 300)
                run_scenario();
        end
        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("password_door_lock_controller_unit test passed");
        else
            $display("password_door_lock_controller_unit test failed");
        $finish;
    end
endmodule
